// ----- design/bmm_pkg.sv -----
// Shared types and constants for the bf16 matrix block with fp32 accumulation.
// Used by the controller, the datapath, the fp multiply-add pipeline and the top level.
// No dependencies.
package bmm_pkg;

    localparam int COL_BITS    = 8;   // holds any column index up to 256 columns
    localparam int ROW_BITS    = 10;  // holds any k row up to 1024 rows
    localparam int EW          = 11;  // signed exponent width inside the adder
    localparam int FADD_STAGES = 6;   // register stages in the multiply-add unit

    localparam logic [1:0] OP_WEIGHT = 2'd0;
    localparam logic [1:0] OP_BIAS   = 2'd1;
    localparam logic [1:0] OP_ACT    = 2'd2;

    localparam logic [1:0] REG_ROW_LENGTH   = 2'd0;
    localparam logic [1:0] REG_COLUMN_COUNT = 2'd1;
    localparam logic [1:0] REG_BIAS_ON      = 2'd2;

    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

    typedef struct packed {
        logic [1:0]  operation;
        logic [5:0]  inner_index;
        logic [5:0]  column_index;
        logic [31:0] value_bits;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  out_column;
        logic [31:0] sum_bits;
        logic        row_done;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic                issue;
        logic                is_out;
        logic                last;
        logic [COL_BITS-1:0] col;
        logic [ROW_BITS-1:0] row;
        logic                wt_we;
        logic                bias_we;
        logic                x_load;
        logic                acc_clear;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic en;
        logic busy;
    } status_t;

endpackage

// ----- design/bmm_fadd.sv -----
// Six-stage exact bf16 product / fp32 add unit with one RNE rounding.
// Depends on bmm_pkg.
// Stages: decode+multiply, normalise, order, align+add, leading one, round.
module bmm_fadd
    import bmm_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a_bits,
    input  logic [15:0] x_bits,
    input  logic [15:0] w_bits,
    input  logic [31:0] b_bits,
    input  logic        use_b,
    output logic [31:0] sum_bits
);

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        logic       done;
        begin
            n    = 5'd0;
            done = 1'b0;
            for (int i = 23; i >= 0; i--)
            begin
                if (!done)
                begin
                    if (v[i])
                        done = 1'b1;
                    else
                        n = n + 5'd1;
                end
            end
            return n;
        end
    endfunction

    function automatic logic [4:0] msb28(input logic [27:0] v);
        logic [4:0] p;
        begin
            p = 5'd0;
            for (int i = 0; i < 28; i++)
            begin
                if (v[i])
                    p = 5'(i);
            end
            return p;
        end
    endfunction

    // ---------------- stage 0: decode, exact product or bias operand
    logic                 s0_as_reg, s0_an_reg, s0_ai_reg;
    logic [23:0]          s0_am_reg;
    logic signed [EW-1:0] s0_ae_reg;
    logic                 s0_bs_reg, s0_bn_reg, s0_bi_reg;
    logic [23:0]          s0_bm_reg;
    logic signed [EW-1:0] s0_be_reg;

    logic                 s0_as_next, s0_an_next, s0_ai_next;
    logic [23:0]          s0_am_next;
    logic signed [EW-1:0] s0_ae_next;
    logic                 s0_bs_next, s0_bn_next, s0_bi_next;
    logic [23:0]          s0_bm_next;
    logic signed [EW-1:0] s0_be_next;

    logic [7:0]           xe, we, fe;
    logic [7:0]           xm, wm;
    logic signed [EW-1:0] xx, wx;
    logic                 xn, xi, xz, wn, wi, wz;

    always_comb
    begin
        s0_as_next = a_bits[31];
        s0_an_next = (a_bits[30:23] == 8'hFF) && (a_bits[22:0] != 23'd0);
        s0_ai_next = (a_bits[30:23] == 8'hFF) && (a_bits[22:0] == 23'd0);
        s0_am_next = {(a_bits[30:23] != 8'd0), a_bits[22:0]};
        s0_ae_next = (a_bits[30:23] != 8'd0) ? $signed({3'b000, a_bits[30:23]}) - 11'sd150
                                             : -11'sd149;

        xe = x_bits[14:7];
        we = w_bits[14:7];
        fe = b_bits[30:23];
        xm = {(xe != 8'd0), x_bits[6:0]};
        wm = {(we != 8'd0), w_bits[6:0]};
        xx = (xe != 8'd0) ? $signed({3'b000, xe}) - 11'sd134 : -11'sd133;
        wx = (we != 8'd0) ? $signed({3'b000, we}) - 11'sd134 : -11'sd133;
        xn = (xe == 8'hFF) && (x_bits[6:0] != 7'd0);
        xi = (xe == 8'hFF) && (x_bits[6:0] == 7'd0);
        xz = (xe == 8'd0) && (x_bits[6:0] == 7'd0);
        wn = (we == 8'hFF) && (w_bits[6:0] != 7'd0);
        wi = (we == 8'hFF) && (w_bits[6:0] == 7'd0);
        wz = (we == 8'd0) && (w_bits[6:0] == 7'd0);

        if (use_b)
        begin
            s0_bs_next = b_bits[31];
            s0_bn_next = (fe == 8'hFF) && (b_bits[22:0] != 23'd0);
            s0_bi_next = (fe == 8'hFF) && (b_bits[22:0] == 23'd0);
            s0_bm_next = {(fe != 8'd0), b_bits[22:0]};
            s0_be_next = (fe != 8'd0) ? $signed({3'b000, fe}) - 11'sd150 : -11'sd149;
        end
        else
        begin
            s0_bs_next = x_bits[15] ^ w_bits[15];
            // Inf times zero is invalid
            s0_bn_next = xn || wn || ((xi || wi) && (xz || wz));
            s0_bi_next = (xi || wi) && !s0_bn_next;
            s0_bm_next = {8'd0, 16'(16'(xm) * 16'(wm))};
            s0_be_next = xx + wx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_as_reg <= s0_as_next;
            s0_an_reg <= s0_an_next;
            s0_ai_reg <= s0_ai_next;
            s0_am_reg <= s0_am_next;
            s0_ae_reg <= s0_ae_next;
            s0_bs_reg <= s0_bs_next;
            s0_bn_reg <= s0_bn_next;
            s0_bi_reg <= s0_bi_next;
            s0_bm_reg <= s0_bm_next;
            s0_be_reg <= s0_be_next;
        end
    end

    // ---------------- stage 1: normalise, specials
    logic                 s1_as_reg, s1_az_reg, s1_bs_reg, s1_bz_reg;
    logic [23:0]          s1_am_reg, s1_bm_reg;
    logic signed [EW-1:0] s1_ae_reg, s1_be_reg;
    logic                 s1_spec_reg;
    logic [31:0]          s1_sbits_reg;

    logic [4:0]           alz, blz;
    logic                 s1_spec_next;
    logic [31:0]          s1_sbits_next;
    logic                 az, bz;

    always_comb
    begin
        alz = lzc24(s0_am_reg);
        blz = lzc24(s0_bm_reg);
        az  = (s0_am_reg == 24'd0) && !s0_an_reg && !s0_ai_reg;
        bz  = (s0_bm_reg == 24'd0) && !s0_bn_reg && !s0_bi_reg;
        s1_spec_next  = 1'b1;
        s1_sbits_next = QNAN_BITS;
        if (s0_an_reg || s0_bn_reg)
            s1_sbits_next = QNAN_BITS;
        else if (s0_ai_reg && s0_bi_reg)
            s1_sbits_next = (s0_as_reg == s0_bs_reg) ? {s0_as_reg, 8'hFF, 23'd0} : QNAN_BITS;
        else if (s0_ai_reg)
            s1_sbits_next = {s0_as_reg, 8'hFF, 23'd0};
        else if (s0_bi_reg)
            s1_sbits_next = {s0_bs_reg, 8'hFF, 23'd0};
        else if (az && bz)
            s1_sbits_next = {s0_as_reg & s0_bs_reg, 31'd0};
        else
            s1_spec_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_as_reg    <= s0_as_reg;
            s1_bs_reg    <= s0_bs_reg;
            s1_az_reg    <= az;
            s1_bz_reg    <= bz;
            s1_am_reg    <= s0_am_reg << alz;
            s1_bm_reg    <= s0_bm_reg << blz;
            s1_ae_reg    <= s0_ae_reg - $signed({6'd0, alz});
            s1_be_reg    <= s0_be_reg - $signed({6'd0, blz});
            s1_spec_reg  <= s1_spec_next;
            s1_sbits_reg <= s1_sbits_next;
        end
    end

    // ---------------- stage 2: larger magnitude first
    logic                 s2_xs_reg, s2_sub_reg, s2_spec_reg;
    logic [23:0]          s2_xm_reg, s2_ym_reg;
    logic signed [EW-1:0] s2_xe_reg;
    logic [EW-1:0]        s2_d_reg;
    logic [31:0]          s2_sbits_reg;
    logic                 a_big;

    always_comb
    begin
        a_big = s1_bz_reg ||
                (!s1_az_reg && ({~s1_ae_reg[EW-1], s1_ae_reg[EW-2:0], s1_am_reg} >=
                                {~s1_be_reg[EW-1], s1_be_reg[EW-2:0], s1_bm_reg}));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_xs_reg    <= a_big ? s1_as_reg : s1_bs_reg;
            s2_sub_reg   <= s1_as_reg ^ s1_bs_reg;
            s2_xm_reg    <= a_big ? s1_am_reg : s1_bm_reg;
            s2_ym_reg    <= a_big ? (s1_bz_reg ? 24'd0 : s1_bm_reg)
                                  : (s1_az_reg ? 24'd0 : s1_am_reg);
            s2_xe_reg    <= a_big ? s1_ae_reg : s1_be_reg;
            s2_d_reg     <= a_big ? EW'(s1_ae_reg - s1_be_reg) : EW'(s1_be_reg - s1_ae_reg);
            s2_spec_reg  <= s1_spec_reg;
            s2_sbits_reg <= s1_sbits_reg;
        end
    end

    // ---------------- stage 3: align with sticky, add or subtract
    logic                 s3_sign_reg, s3_spec_reg;
    logic [27:0]          s3_s_reg;
    logic signed [EW-1:0] s3_e_reg;
    logic [31:0]          s3_sbits_reg;
    logic [26:0]          xw, yw, yal, lmask;

    always_comb
    begin
        xw    = {s2_xm_reg, 3'b000};
        yw    = {s2_ym_reg, 3'b000};
        lmask = (27'd1 << s2_d_reg[4:0]) - 27'd1;
        if (s2_d_reg >= EW'(27))
            yal = 27'(s2_ym_reg != 24'd0);
        else
            yal = (yw >> s2_d_reg[4:0]) | 27'((yw & lmask) != 27'd0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_s_reg     <= s2_sub_reg ? ({1'b0, xw} - {1'b0, yal}) : ({1'b0, xw} + {1'b0, yal});
            s3_e_reg     <= s2_xe_reg - 11'sd3;
            s3_sign_reg  <= s2_xs_reg;
            s3_spec_reg  <= s2_spec_reg;
            s3_sbits_reg <= s2_sbits_reg;
        end
    end

    // ---------------- stage 4: leading one, rounding position
    logic                 s4_sign_reg, s4_spec_reg, s4_zero_reg;
    logic [27:0]          s4_s_reg;
    logic signed [EW-1:0] s4_q_reg, s4_sh_reg;
    logic [31:0]          s4_sbits_reg;
    logic signed [EW-1:0] q4;

    always_comb
    begin
        q4 = $signed({6'd0, msb28(s3_s_reg)}) + s3_e_reg - 11'sd23;
        if (q4 < -11'sd149)
            q4 = -11'sd149;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_s_reg     <= s3_s_reg;
            s4_q_reg     <= q4;
            s4_sh_reg    <= q4 - s3_e_reg;
            s4_zero_reg  <= (s3_s_reg == 28'd0);
            s4_sign_reg  <= s3_sign_reg;
            s4_spec_reg  <= s3_spec_reg;
            s4_sbits_reg <= s3_sbits_reg;
        end
    end

    // ---------------- stage 5: shift and round to nearest even
    logic                 s5_sign_reg, s5_spec_reg, s5_zero_reg;
    logic [24:0]          s5_r_reg;
    logic signed [EW-1:0] s5_q_reg;
    logic [31:0]          s5_sbits_reg;
    logic [24:0]          r5;
    logic [EW-1:0]        nsh;
    logic [4:0]           shr;
    logic [27:0]          t5, rem5, half5;

    always_comb
    begin
        nsh   = EW'(-s4_sh_reg);
        shr   = s4_sh_reg[4:0];
        t5    = s4_s_reg >> shr;
        rem5  = s4_s_reg & ((28'd1 << shr) - 28'd1);
        half5 = 28'd1 << (shr - 5'd1);
        if (s4_sh_reg <= 11'sd0)
            r5 = 25'(s4_s_reg << nsh[4:0]);
        else if (s4_sh_reg > 11'sd28)
            r5 = 25'd0;
        else
            r5 = 25'(t5) + 25'((rem5 > half5) || ((rem5 == half5) && t5[0]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_r_reg     <= r5;
            s5_q_reg     <= s4_q_reg;
            s5_zero_reg  <= s4_zero_reg;
            s5_sign_reg  <= s4_sign_reg;
            s5_spec_reg  <= s4_spec_reg;
            s5_sbits_reg <= s4_sbits_reg;
        end
    end

    // ---------------- pack
    logic [24:0]          rp;
    logic signed [EW-1:0] qp;

    always_comb
    begin
        rp = s5_r_reg;
        qp = s5_q_reg;
        if (rp >= 25'h100_0000)
        begin
            rp = rp >> 1;
            qp = qp + 11'sd1;
        end
        if (s5_spec_reg)
            sum_bits = s5_sbits_reg;
        else if (s5_zero_reg)
            sum_bits = 32'd0;
        else if (s5_r_reg == 25'd0)
            sum_bits = {s5_sign_reg, 31'd0};
        else if (s5_r_reg < 25'h80_0000)
            sum_bits = {s5_sign_reg, 8'd0, s5_r_reg[22:0]};
        else if (qp >= 11'sd105)
            sum_bits = {s5_sign_reg, 8'hFF, 23'd0};
        else
            sum_bits = {s5_sign_reg, 8'(qp + 11'sd150), rp[22:0]};
    end

endmodule

// ----- design/bmm_datapath.sv -----
// Datapath: weight, bias and accumulator stores, the shared multiply-add unit,
// the tag pipeline and the output register. Depends on bmm_pkg and bmm_fadd.
module bmm_datapath
    import bmm_pkg::*;
#(
    parameter int MAX_INNER   = 64,
    parameter int MAX_COLUMNS = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd,
    output status_t   status,
    input  in_item_t  item,
    input  logic      bias_on,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    localparam int AW = $clog2(MAX_INNER * MAX_COLUMNS);
    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int RI = $clog2(MAX_INNER);
    localparam int N  = FADD_STAGES;

    logic [15:0] wmem [MAX_INNER * MAX_COLUMNS];
    logic [31:0] bmem [MAX_COLUMNS];
    logic [31:0] amem [MAX_COLUMNS];
    logic [MAX_COLUMNS-1:0] acc_vld_reg;

    logic [15:0] x_reg;
    logic [15:0] wt_q_reg;
    logic [31:0] bias_q_reg, acc_q_reg;
    logic        accv_q_reg;

    logic          v_reg    [N+1];
    logic          out_reg  [N+1];
    logic          last_reg [N+1];
    logic [CW-1:0] col_reg  [N+1];

    logic          result_valid_reg;
    out_item_t     result_reg;

    logic          en;
    logic [AW-1:0] waddr, raddr;
    logic [CW-1:0] rcol, bcol;
    logic [31:0]   sum;
    logic          acc_we;
    logic          busy;

    assign en    = !(result_valid_reg && result_stall);
    assign rcol  = cmd.col[CW-1:0];
    assign bcol  = CW'(item.column_index);
    assign raddr = AW'(AW'(cmd.row[RI-1:0]) * AW'(MAX_COLUMNS) + AW'(rcol));
    assign waddr = AW'(AW'(item.inner_index) * AW'(MAX_COLUMNS) + AW'(item.column_index));
    assign acc_we = en && v_reg[N] && !out_reg[N];

    always_comb
    begin
        busy = 1'b0;
        for (int i = 0; i <= N; i++)
            busy = busy | v_reg[i];
    end

    assign status.en   = en;
    assign status.busy = busy;

    always_ff @(posedge clk)
    begin
        if (cmd.wt_we)
            wmem[waddr] <= item.value_bits[15:0];
        if (en && cmd.issue)
            wt_q_reg <= wmem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.bias_we)
            bmem[bcol] <= item.value_bits;
        if (en && cmd.issue)
            bias_q_reg <= bmem[rcol];
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
            amem[col_reg[N]] <= sum;
        if (en && cmd.issue)
            acc_q_reg <= amem[rcol];
    end

    // entries without a valid bit read as +0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_vld_reg <= '0;
        else if (cmd.acc_clear)
            acc_vld_reg <= '0;
        else if (acc_we)
            acc_vld_reg[col_reg[N]] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.x_load)
            x_reg <= item.value_bits[15:0];
        if (en && cmd.issue)
            accv_q_reg <= acc_vld_reg[rcol];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= N; i++)
                v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= cmd.issue;
            for (int i = 1; i <= N; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg[0]  <= cmd.is_out;
            last_reg[0] <= cmd.last;
            col_reg[0]  <= rcol;
            for (int i = 1; i <= N; i++)
            begin
                out_reg[i]  <= out_reg[i-1];
                last_reg[i] <= last_reg[i-1];
                col_reg[i]  <= col_reg[i-1];
            end
        end
    end

    bmm_fadd u_fadd (
        .clk      (clk),
        .en       (en),
        .a_bits   (accv_q_reg ? acc_q_reg : 32'd0),
        .x_bits   (x_reg),
        .w_bits   (wt_q_reg),
        .b_bits   (bias_on ? bias_q_reg : 32'd0),
        .use_b    (out_reg[0]),
        .sum_bits (sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (en)
            result_valid_reg <= v_reg[N] && out_reg[N];
    end

    always_ff @(posedge clk)
    begin
        if (en && v_reg[N] && out_reg[N])
        begin
            result_reg.out_column <= 6'(col_reg[N]);
            result_reg.sum_bits   <= sum;
            result_reg.row_done   <= last_reg[N];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- design/bmm_ctrl.sv -----
// Controller: input item decode, column issue passes and row sequencing.
// Depends on bmm_pkg.
module bmm_ctrl
    import bmm_pkg::*;
#(
    parameter int MAX_INNER   = 64,
    parameter int MAX_COLUMNS = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    input  in_item_t item,
    input  logic [6:0] row_length,
    input  logic [6:0] column_count,
    input  status_t  status,
    output cmd_t     cmd
);

    localparam int KW   = $clog2(MAX_INNER + 1);
    localparam int CW   = $clog2(MAX_COLUMNS);
    localparam int MLIM = (MAX_COLUMNS < 64) ? MAX_COLUMNS : 64;

    typedef enum logic [2:0] {S_IDLE, S_ACCUM, S_ACC_DRAIN, S_OUTPUT} state_t;

    state_t        state_reg;
    logic [KW-1:0] pos_reg;
    logic [CW-1:0] col_reg;
    logic [KW-1:0] row_reg;
    logic          last_reg;

    logic [10:0]   kmax, rl, kcur;
    logic [6:0]    mcnt;
    logic          accept, col_end;

    always_comb
    begin
        rl = 11'(row_length);
        if (rl == 11'd0)
            kmax = 11'd1;
        else if (rl > 11'(MAX_INNER))
            kmax = 11'(MAX_INNER);
        else
            kmax = rl;
        if (column_count == 7'd0)
            mcnt = 7'd1;
        else if (column_count > 7'(MLIM))
            mcnt = 7'(MLIM);
        else
            mcnt = column_count;
        kcur = (11'(pos_reg) >= 11'(MAX_INNER)) ? 11'(MAX_INNER - 1) : 11'(pos_reg);
    end

    assign accept     = item_valid && (state_reg == S_IDLE);
    assign item_stall = (state_reg != S_IDLE);
    assign col_end    = (9'(col_reg) == 9'(mcnt) - 9'd1);

    always_comb
    begin
        cmd           = '0;
        cmd.col       = COL_BITS'(col_reg);
        cmd.row       = ROW_BITS'(row_reg);
        cmd.last      = col_end;
        cmd.wt_we     = accept && (item.operation == OP_WEIGHT) &&
                        (11'(item.inner_index) < 11'(MAX_INNER)) &&
                        (11'(item.column_index) < 11'(MAX_COLUMNS));
        cmd.bias_we   = accept && (item.operation == OP_BIAS) &&
                        (11'(item.column_index) < 11'(MAX_COLUMNS));
        cmd.x_load    = accept && (item.operation == OP_ACT);
        case (state_reg)
            S_ACCUM:
            begin
                cmd.issue = status.en;
            end
            S_OUTPUT:
            begin
                cmd.issue     = status.en;
                cmd.is_out    = 1'b1;
                cmd.acc_clear = status.en && col_end;
            end
            default:
            begin
                cmd.issue = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.x_load)
                    begin
                        row_reg   <= KW'(kcur);
                        pos_reg   <= KW'(kcur + 11'd1);
                        last_reg  <= (kcur + 11'd1 >= kmax);
                        col_reg   <= '0;
                        state_reg <= S_ACCUM;
                    end
                end
                S_ACCUM:
                begin
                    if (status.en)
                    begin
                        if (col_end)
                            state_reg <= S_ACC_DRAIN;
                        else
                            col_reg <= col_reg + 1'b1;
                    end
                end
                S_ACC_DRAIN:
                begin
                    // writes back to the accumulators must land before they are read again
                    if (!status.busy)
                    begin
                        col_reg <= '0;
                        if (last_reg)
                        begin
                            pos_reg   <= '0;
                            state_reg <= S_OUTPUT;
                        end
                        else
                            state_reg <= S_IDLE;
                    end
                end
                S_OUTPUT:
                begin
                    if (status.en)
                    begin
                        if (col_end)
                            state_reg <= S_IDLE;
                        else
                            col_reg <= col_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_load_starts_pass: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.x_load |=> (state_reg == S_ACCUM))
        else $error("activation item did not start an accumulate pass");

    a_clear_on_last_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_clear |-> (cmd.issue && cmd.is_out && cmd.last))
        else $error("accumulators cleared outside the last output issue");

    a_drain_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_ACC_DRAIN) && !status.busy && !last_reg) |=> (state_reg == S_IDLE))
        else $error("mid-row element did not return to idle after drain");

    a_out_pass_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_ACC_DRAIN) && !status.busy && last_reg) |=> (pos_reg == '0))
        else $error("element position not cleared at row end");

endmodule

// ----- design/bf16_matmul_fp32_bias.sv -----
// bf16 x bf16 matrix-vector block, fp32 accumulate, fp32 bias.
// Activation element: one issue per column (one column per cycle while the
// output is not stalled, through the shared 7-stage read + multiply-add
// pipeline), then a drain until that pipeline is empty; the row's last element
// adds an output pass over every column. Throughput is set by that single unit.
// Reset: control and config registers cleared to defaults; accumulators read +0.
module bf16_matmul_fp32_bias
    import bmm_pkg::*;
#(
    parameter int MAX_INNER   = 64,
    parameter int MAX_COLUMNS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  in_item_t    item,
    output logic        result_valid,
    input  logic        result_stall,
    output out_item_t   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [6:0] row_length_reg;
    logic [6:0] column_count_reg;
    logic       bias_on_reg;
    logic       wr;
    cmd_t       cmd;
    status_t    status;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg   <= 7'd64;
            column_count_reg <= 7'd64;
            bias_on_reg      <= 1'b0;
        end
        else if (wr)
        begin
            case (paddr[3:2])
                REG_ROW_LENGTH:   row_length_reg   <= pwdata[6:0];
                REG_COLUMN_COUNT: column_count_reg <= pwdata[6:0];
                REG_BIAS_ON:      bias_on_reg      <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_ROW_LENGTH:   prdata = {25'd0, row_length_reg};
            REG_COLUMN_COUNT: prdata = {25'd0, column_count_reg};
            REG_BIAS_ON:      prdata = {31'd0, bias_on_reg};
            default:          prdata = 32'd0;
        endcase
    end

    bmm_ctrl #(
        .MAX_INNER   (MAX_INNER),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .row_length   (row_length_reg),
        .column_count (column_count_reg),
        .status       (status),
        .cmd          (cmd)
    );

    bmm_datapath #(
        .MAX_INNER   (MAX_INNER),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item         (item),
        .bias_on      (bias_on_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
